// ----- hdl/wra_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, command codes and divider request/response types for the running average.
package wra_pkg;

	localparam int unsigned WORD_W     = 32;
	localparam int unsigned IDX_W      = 12;
	localparam int unsigned CMD_W      = 2;
	localparam int unsigned STEP_W     = 32;
	localparam int unsigned NUM_W      = 64;
	localparam int unsigned DEN_W      = STEP_W + 1;
	localparam int unsigned S_DATA_W   = 48;
	localparam int unsigned M_DATA_W   = WORD_W;
	localparam int unsigned M_USER_W   = 2;
	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CMD_W-1:0] CMD_STEP   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RECORD = 2'd1;

	// word index of the start_after register (paddr bit 2)
	localparam logic REG_START_AFTER = 1'b0;

	localparam logic [STEP_W-1:0] STEP_MAX = '1;

	typedef struct packed {
		logic                    start;
		logic signed [NUM_W-1:0] num;
		logic [DEN_W-1:0]        den;
	} div_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [WORD_W-1:0] quo;
	} div_rsp_t;

endpackage

// ----- hdl/wra_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module wra_ram #(
	parameter int unsigned WIDTH  = 32,
	parameter int unsigned DEPTH  = 4096,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/wra_div.sv -----
`timescale 1ns / 1ps
// Signed 64-by-33-bit restoring divider, one quotient bit per cycle, truncating toward zero.
module wra_div (
	input  logic              clk,
	input  logic              arst_n,
	input  wra_pkg::div_req_t req,
	output wra_pkg::div_rsp_t rsp
);

	localparam int unsigned QUO_W = wra_pkg::WORD_W;
	localparam int unsigned NUM_W = wra_pkg::NUM_W;
	localparam int unsigned DEN_W = wra_pkg::DEN_W;
	localparam int unsigned CNT_W = $clog2(QUO_W + 1);

	logic                    busy_q;
	logic                    fin_q;
	logic                    done_q;
	logic                    neg_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [DEN_W-1:0]        rem_q;
	logic [DEN_W-1:0]        den_q;
	logic [QUO_W-1:0]        dvd_q;
	logic signed [QUO_W-1:0] res_q;
	logic [NUM_W-1:0]        mag;
	logic [DEN_W:0]          trial;
	logic [DEN_W:0]          diff;
	logic                    fits;

	assign mag   = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
	assign trial = {rem_q, dvd_q[QUO_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q  <= 1'b0;
			done_q <= fin_q;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	// quotient |num| / den fits in QUO_W bits, so the upper half starts below den
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= DEN_W'(mag[NUM_W-1:QUO_W]);
			dvd_q <= mag[QUO_W-1:0];
			den_q <= req.den;
			neg_q <= req.num[NUM_W-1];
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			dvd_q <= {dvd_q[QUO_W-2:0], fits};
		end
		if (fin_q) begin
			res_q <= neg_q ? QUO_W'(-dvd_q) : dvd_q;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = res_q;

endmodule

// ----- hdl/weight_running_average_top.sv -----
`timescale 1ns / 1ps
// Top level of the running weight average: table memory, step counter, sequencer and APB register.
//
// The block takes one item at a time. A step item that updates the average goes through a table
// read, a 32x33-bit multiply, a 64-bit add, then the divider (one quotient bit per cycle) and
// write-back before the next item is accepted. Every other item goes through table read, then
// result. Results wait in an output register, so a result that is not yet taken stalls only the
// end of the following item. After reset the table is cleared one entry per cycle while
// s_tready stays low; APB writes are taken throughout.
module weight_running_average_top #(
	parameter int unsigned WEIGHT_COUNT = 4096,
	parameter int unsigned WEIGHT_BITS  = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [wra_pkg::S_DATA_W-1:0]       s_tdata,  // weight_index[11:0], weight_value[43:12]
	input  logic [wra_pkg::CMD_W-1:0]          s_tuser,  // command[1:0]
	input  logic                               s_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [wra_pkg::M_DATA_W-1:0]       m_tdata,  // average_value[31:0]
	output logic [wra_pkg::M_USER_W-1:0]       m_tuser,  // averaging_applied[0], is_initialized[1]
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [wra_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [wra_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [wra_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                               pready
);

	localparam int unsigned WORD_W = wra_pkg::WORD_W;
	localparam int unsigned IDX_W  = wra_pkg::IDX_W;
	localparam int unsigned STEP_W = wra_pkg::STEP_W;
	localparam int unsigned NUM_W  = wra_pkg::NUM_W;
	localparam int unsigned DEN_W  = wra_pkg::DEN_W;
	localparam int unsigned ADDR_W = (WEIGHT_COUNT > 1) ? $clog2(WEIGHT_COUNT) : 1;
	localparam int unsigned SHAMT  = WORD_W - WEIGHT_BITS;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WEIGHT_COUNT - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_SUM  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	function automatic logic signed [WORD_W-1:0] sext_w(input logic [WORD_W-1:0] v);
		logic signed [WORD_W-1:0] t;
		t = $signed(v << SHAMT);
		return t >>> SHAMT;
	endfunction

	logic [2:0]                    state_q;
	logic [STEP_W-1:0]             start_after_q;
	logic [STEP_W-1:0]             steps_q;
	logic                          started_q;
	logic                          clr_busy_q;
	logic [ADDR_W-1:0]             clr_addr_q;
	logic [wra_pkg::CMD_W-1:0]     cmd_q;
	logic [ADDR_W-1:0]             idx_q;
	logic signed [WORD_W-1:0]      w_q;
	logic                          in_range_q;
	logic                          apply_q;
	logic                          record_ok_q;
	logic [STEP_W-1:0]             nm1_q;
	logic signed [NUM_W-1:0]       prod_q;
	logic signed [NUM_W-1:0]       num_q;
	logic signed [WORD_W-1:0]      result_q;
	logic                          m_tvalid_q;
	logic [WORD_W-1:0]             m_data_q;
	logic [wra_pkg::M_USER_W-1:0]  m_user_q;

	logic                          accept;
	logic                          cfg_wr;
	logic [wra_pkg::CMD_W-1:0]     in_cmd;
	logic [IDX_W-1:0]              in_idx;
	logic signed [WORD_W-1:0]      in_w;
	logic                          in_range;
	logic                          out_free;
	logic                          ram_wr_en;
	logic [ADDR_W-1:0]             ram_wr_addr;
	logic [WEIGHT_BITS-1:0]        ram_wr_data;
	logic [WEIGHT_BITS-1:0]        ram_rd_data;
	logic signed [WORD_W-1:0]      old_ext;
	logic signed [WORD_W-1:0]      stored;
	logic signed [WORD_W-1:0]      quo_ext;
	logic signed [NUM_W:0]         prod_full;
	wra_pkg::div_req_t             div_req;
	wra_pkg::div_rsp_t             div_rsp;

	assign in_cmd   = s_tuser;
	assign in_idx   = s_tdata[IDX_W-1:0];
	assign in_w     = sext_w(s_tdata[IDX_W+WORD_W-1:IDX_W]);
	assign in_range = (STEP_W'(in_idx) < STEP_W'(WEIGHT_COUNT));
	assign s_tready = (state_q == ST_IDLE) && !clr_busy_q;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == wra_pkg::REG_START_AFTER);
	assign prdata = (paddr[2] == wra_pkg::REG_START_AFTER) ? start_after_q : '0;

	assign old_ext   = sext_w(WORD_W'(ram_rd_data));
	assign stored    = in_range_q ? old_ext : '0;
	assign quo_ext   = sext_w(div_rsp.quo);
	assign prod_full = old_ext * $signed({1'b0, nm1_q});

	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = idx_q;
		ram_wr_data = w_q[WEIGHT_BITS-1:0];
		if (clr_busy_q) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = clr_addr_q;
			ram_wr_data = '0;
		end else if (state_q == ST_READ) begin
			ram_wr_en = !apply_q && record_ok_q;
		end else if (state_q == ST_DIV) begin
			ram_wr_en   = div_rsp.done;
			ram_wr_data = div_rsp.quo[WEIGHT_BITS-1:0];
		end
	end

	always_comb begin
		div_req.start = (state_q == ST_SUM);
		div_req.num   = num_q;
		div_req.den   = DEN_W'({1'b0, nm1_q}) + DEN_W'(1);
	end

	wra_ram #(
		.WIDTH  (WEIGHT_BITS),
		.DEPTH  (WEIGHT_COUNT),
		.ADDR_W (ADDR_W)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (accept),
		.rd_addr (ADDR_W'(in_idx)),
		.rd_data (ram_rd_data)
	);

	wra_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_after_q <= '0;
			steps_q       <= '0;
			started_q     <= 1'b0;
			clr_busy_q    <= 1'b1;
			clr_addr_q    <= '0;
			state_q       <= ST_IDLE;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (cfg_wr) begin
				start_after_q <= pwdata;
			end
			if (clr_busy_q) begin
				if (clr_addr_q == LAST_ADDR) begin
					clr_busy_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
				end
			end
			if (accept && (in_cmd == wra_pkg::CMD_STEP)) begin
				started_q <= 1'b1;
				if (s_tlast && (steps_q != wra_pkg::STEP_MAX)) begin
					steps_q <= steps_q + STEP_W'(1);
				end
			end
			if (m_tvalid_q && m_tready && (state_q != ST_OUT)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= apply_q ? ST_MUL : ST_OUT;
				end
				ST_MUL: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q       <= in_cmd;
			idx_q       <= ADDR_W'(in_idx);
			w_q         <= in_w;
			in_range_q  <= in_range;
			apply_q     <= (in_cmd == wra_pkg::CMD_STEP) && in_range &&
			               (steps_q >= start_after_q);
			record_ok_q <= (in_cmd == wra_pkg::CMD_RECORD) && started_q && in_range;
			nm1_q       <= steps_q - start_after_q;
		end
		if (state_q == ST_READ) begin
			prod_q <= prod_full[NUM_W-1:0];
			case (cmd_q)
				wra_pkg::CMD_RECORD: begin
					result_q <= record_ok_q ? w_q : stored;
				end
				default: begin
					result_q <= stored;
				end
			endcase
		end
		if (state_q == ST_MUL) begin
			num_q <= prod_q + NUM_W'(w_q);
		end
		if ((state_q == ST_DIV) && div_rsp.done) begin
			result_q <= quo_ext;
		end
		if ((state_q == ST_OUT) && out_free) begin
			m_data_q <= result_q;
			m_user_q <= {started_q, apply_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

`ifndef SYNTH
	a_applied_initialized: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tuser[1])
		else $error("average applied before initialization");

	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> (state_q == ST_IDLE))
		else $error("item in flight during table clear");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("divider finished outside divide state");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("second item accepted while one is in flight");
`endif

endmodule

// ----- sim/tb_weight_running_average_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for weight_running_average_top: APB setup, streamed weights, result check.
module tb_weight_running_average_top;

	localparam int unsigned TABLE_DEPTH = 4096;
	localparam logic [wra_pkg::CMD_W-1:0] CMD_READ  = 2'd2;
	localparam logic [wra_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
	localparam int unsigned QUIET_LIMIT = 20000;
	localparam int unsigned PHASE_ITEMS = 250;

	typedef struct packed {
		logic [wra_pkg::WORD_W-1:0] average;
		logic                       applied;
		logic                       initialized;
	} avg_result_t;

	class avg_scoreboard;
		bit signed [wra_pkg::WORD_W-1:0] avg_table [TABLE_DEPTH];
		bit [wra_pkg::STEP_W-1:0]        steps_done;
		bit                              started;
		bit [wra_pkg::CFG_DATA_W-1:0]    start_after;
		avg_result_t                     pending [$];
		int unsigned                     fails;
		int unsigned                     taken;
		int unsigned                     checked;
		int unsigned                     averaged;

		function void note_item(logic [wra_pkg::CMD_W-1:0] cmd, logic [wra_pkg::IDX_W-1:0] idx,
				logic signed [wra_pkg::WORD_W-1:0] w, logic last);
			avg_result_t r;
			longint      n;
			longint      old;
			longint      num;
			r.applied = 1'b0;
			if (cmd == wra_pkg::CMD_STEP) begin
				started = 1'b1;
				if (steps_done >= start_after && idx < TABLE_DEPTH) begin
					n = {32'd0, steps_done - start_after};
					n = n + 1;
					old = avg_table[idx];
					num = old * (n - 1) + w;
					avg_table[idx] = wra_pkg::WORD_W'(num / n);
					r.applied = 1'b1;
				end
				if (last && steps_done != wra_pkg::STEP_MAX)
					steps_done++;
			end else if (cmd == wra_pkg::CMD_RECORD) begin
				if (started && idx < TABLE_DEPTH)
					avg_table[idx] = w;
			end
			r.average = (idx < TABLE_DEPTH) ? avg_table[idx] : '0;
			r.initialized = started;
			pending = {pending, r};
			taken++;
		endfunction

		function void check_result(logic [wra_pkg::M_DATA_W-1:0] data,
				logic [wra_pkg::M_USER_W-1:0] user);
			avg_result_t r;
			if (pending.size() == 0) begin
				$error("result transaction with nothing expected: data %h user %b", data, user);
				fails++;
				return;
			end
			r = pending.pop_front();
			checked++;
			if (user[0])
				averaged++;
			if (data !== r.average) begin
				$error("average_value expected %0d got %0d", $signed(r.average), $signed(data));
				fails++;
			end
			if (user[0] !== r.applied) begin
				$error("averaging_applied expected %0b got %0b", r.applied, user[0]);
				fails++;
			end
			if (user[1] !== r.initialized) begin
				$error("is_initialized expected %0b got %0b", r.initialized, user[1]);
				fails++;
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [wra_pkg::S_DATA_W-1:0]   s_tdata = '0;
	logic [wra_pkg::CMD_W-1:0]      s_tuser = '0;
	logic                           s_tlast = 1'b0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [wra_pkg::M_DATA_W-1:0]   m_tdata;
	logic [wra_pkg::M_USER_W-1:0]   m_tuser;
	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [wra_pkg::CFG_ADDR_W-1:0] paddr = '0;
	logic [wra_pkg::CFG_DATA_W-1:0] pwdata = '0;
	logic [wra_pkg::CFG_DATA_W-1:0] prdata;
	logic                           pready;

	avg_scoreboard sb = new();
	bit            steady = 1'b0;
	int unsigned   quiet = 0;
	int unsigned   settings = 0;

	weight_running_average_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 11);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_item(input logic [wra_pkg::CMD_W-1:0] cmd,
			input logic [wra_pkg::IDX_W-1:0] idx,
			input logic [wra_pkg::WORD_W-1:0] w, input logic last);
		while (!steady && $urandom_range(0, 99) < 11) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {4'd0, w, idx};
		s_tuser = cmd;
		s_tlast = last;
		do @(posedge clk); while (!s_tready);
		sb.note_item(cmd, idx, w, last);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [wra_pkg::CFG_DATA_W-1:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {wra_pkg::REG_START_AFTER, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.start_after = value;
		settings++;
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== value) begin
			$error("start_after expected %h got %h", value, prdata);
			sb.fails++;
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	function automatic logic [wra_pkg::WORD_W-1:0] rand_weight();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return 32'($urandom_range(0, 400)) - 32'd200;
			default: return $urandom;
		endcase
	endfunction

	task automatic run_phase(input int unsigned count);
		int unsigned               sent;
		int unsigned               len;
		logic [wra_pkg::IDX_W-1:0] idx;
		logic                      last;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 99) < 75) begin
				len = $urandom_range(1, 6);
				for (int k = 0; k < len; k++) begin
					idx = ($urandom_range(0, 9) == 0) ? wra_pkg::IDX_W'($urandom)
					                                  : wra_pkg::IDX_W'(k);
					last = (k == len - 1) && ($urandom_range(0, 9) != 0);
					send_item(wra_pkg::CMD_STEP, idx, rand_weight(), last);
					sent++;
				end
			end else begin
				idx = ($urandom_range(0, 1) == 0) ? wra_pkg::IDX_W'($urandom)
				                                  : wra_pkg::IDX_W'($urandom_range(0, 5));
				send_item(wra_pkg::CMD_W'($urandom_range(0, 3)), idx, rand_weight(),
					1'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		logic [wra_pkg::CFG_DATA_W-1:0] value;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		cfg_write(32'd1);

		send_item(CMD_READ,            12'd0,    32'd0,         1'b0);
		send_item(wra_pkg::CMD_RECORD, 12'd4095, 32'h7FFF_FFFF, 1'b0);
		send_item(CMD_SPARE,           12'd0,    32'h1234_5678, 1'b1);
		send_item(wra_pkg::CMD_STEP,   12'd0,    32'd12345,     1'b0);
		send_item(wra_pkg::CMD_STEP,   12'd4095, 32'h8000_0000, 1'b1);
		send_item(wra_pkg::CMD_STEP,   12'd0,    32'h7FFF_FFFF, 1'b0);
		send_item(wra_pkg::CMD_STEP,   12'd4095, 32'h8000_0000, 1'b0);
		send_item(wra_pkg::CMD_STEP,   12'd7,    -32'sd3,       1'b1);
		send_item(wra_pkg::CMD_STEP,   12'd0,    32'hFFFF_FFFF, 1'b0);
		send_item(wra_pkg::CMD_STEP,   12'd4095, 32'h7FFF_FFFF, 1'b0);
		send_item(wra_pkg::CMD_STEP,   12'd7,    32'd0,         1'b1);
		send_item(wra_pkg::CMD_RECORD, 12'd5,    32'h8000_0000, 1'b0);
		send_item(CMD_READ,            12'd5,    32'd0,         1'b0);
		send_item(wra_pkg::CMD_RECORD, 12'd6,    32'hFFFF_FFFF, 1'b1);
		send_item(CMD_READ,            12'd6,    32'hFFFF_FFFF, 1'b1);
		send_item(CMD_SPARE,           12'd5,    32'h0000_0001, 1'b1);
		send_item(wra_pkg::CMD_STEP,   12'd5,    32'h7FFF_FFFF, 1'b1);
		send_item(CMD_READ,            12'd4095, 32'd0,         1'b0);
		send_item(CMD_READ,            12'd2730, 32'h5555_5555, 1'b0);

		for (int p = 0; p < 6; p++) begin
			drain();
			case (p)
				0: value = 32'd0;
				1: value = sb.steps_done + $urandom_range(3, 15);
				2: value = 32'd3;
				3: value = 32'hFFFF_FFFF;
				4: value = $urandom;
				default: value = sb.steps_done;
			endcase
			cfg_write(value);
			steady = (p == 2);
			run_phase(PHASE_ITEMS);
		end
		steady = 1'b0;

		s_tvalid = 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("Run covered %0d input transactions and %0d checked results, %0d averaged.",
			sb.taken, sb.checked, sb.averaged);
		$display("Threshold settings used: %0d; step count reached %0d.", settings, sb.steps_done);
		if (sb.fails == 0 && sb.pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/wra_pkg.sv
hdl/wra_ram.sv
hdl/wra_div.sv
hdl/weight_running_average_top.sv
sim/tb_weight_running_average_top.sv
